@@ hdl/rowl_pkg.sv @@
// Shared types, constants and helpers for the write-record ring.
`timescale 1ns / 1ps

package rowl_pkg;

	localparam int unsigned DEPTH    = 16;
	localparam int unsigned SLOT_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned HANDLE_W = 32;
	localparam int unsigned SIZE_W   = 16;
	localparam int unsigned OFFSET_W = 20;

	typedef logic [SLOT_W-1:0] slot_t;

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_FIND = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD,
		ST_FIND,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [SIZE_W-1:0]   size;
	} entry_t;

	typedef struct packed {
		logic   we;
		slot_t  waddr;
		entry_t wdata;
		slot_t  raddr;
	} mem_req_t;

	function automatic slot_t next_slot(slot_t s);
		return (s == slot_t'(DEPTH - 1)) ? '0 : slot_t'(s + 1'b1);
	endfunction

endpackage

@@ hdl/rowl_in_if.sv @@
// Input channel: one add or find word with valid/ready handshake.
`timescale 1ns / 1ps

interface rowl_in_if;
	logic                                valid;
	logic                                ready;
	logic                                operation;
	logic [rowl_pkg::HANDLE_W-1:0]       record_handle;
	logic [rowl_pkg::SIZE_W-1:0]         record_size;
	logic [rowl_pkg::OFFSET_W-1:0]       byte_offset;

	modport source (
		output valid, operation, record_handle, record_size, byte_offset,
		input  ready
	);
	modport sink (
		input  valid, operation, record_handle, record_size, byte_offset,
		output ready
	);
endinterface

@@ hdl/rowl_out_if.sv @@
// Result channel: one lookup or eviction word with valid/ready handshake.
`timescale 1ns / 1ps

interface rowl_out_if;
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [rowl_pkg::HANDLE_W-1:0] found_handle;
	logic [rowl_pkg::SIZE_W-1:0]   found_size;
	logic [rowl_pkg::SIZE_W-1:0]   offset_in_record;

	modport source (
		output valid, hit, found_handle, found_size, offset_in_record,
		input  ready
	);
	modport sink (
		input  valid, hit, found_handle, found_size, offset_in_record,
		output ready
	);
endinterface

@@ hdl/ring_of_writes_offset_lookup_unit.sv @@
// Ring of write records with eviction on overflow and byte-offset lookup.
//
// An add is accepted in IDLE and written in ADD; a find walks the ring from
// the oldest record, one record per cycle through the single read port of
// the record memory, until a record holds the byte or the last slot has
// been read. Either result is loaded into the output register from RESP.
// One word is worked on at a time: the next word is accepted once the
// previous result sits in the output register, which holds it until the
// consumer takes it. An add into a full ring returns the overwritten record
// with hit set; a find returns the record holding the byte and the position
// inside it, or all zeros when the offset lies past the stored bytes.
`timescale 1ns / 1ps

module ring_of_writes_offset_lookup_unit (
	input  logic             clk,
	input  logic             arst_n,
	rowl_in_if.sink          item,
	rowl_out_if.source       result
);

	rowl_pkg::state_t                state_q, state_nxt;
	rowl_pkg::slot_t                 wr_slot_q, rd_slot_q, walk_slot_q, proc_q;
	logic                            full_q;
	logic [rowl_pkg::HANDLE_W-1:0]   handle_q;
	logic [rowl_pkg::SIZE_W-1:0]     size_q;
	logic [rowl_pkg::OFFSET_W-1:0]   rem_q;

	logic                            res_hit_q;
	logic [rowl_pkg::HANDLE_W-1:0]   res_handle_q;
	logic [rowl_pkg::SIZE_W-1:0]     res_size_q;
	logic [rowl_pkg::SIZE_W-1:0]     res_off_q;

	logic                            out_valid_q;
	logic                            out_hit_q;
	logic [rowl_pkg::HANDLE_W-1:0]   out_handle_q;
	logic [rowl_pkg::SIZE_W-1:0]     out_size_q;
	logic [rowl_pkg::SIZE_W-1:0]     out_off_q;

	rowl_pkg::mem_req_t              mreq;
	rowl_pkg::entry_t                rdata;
	logic                            find_hit;
	logic                            walk_last;
	logic                            out_free;
	rowl_pkg::slot_t                 wr_next;
	rowl_pkg::slot_t                 rd_next;

	rowl_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rdata  (rdata)
	);

	assign find_hit  = rem_q < rowl_pkg::OFFSET_W'(rdata.size);
	assign walk_last = proc_q == rowl_pkg::slot_t'(rowl_pkg::DEPTH - 1);
	assign out_free  = !out_valid_q || result.ready;
	assign wr_next   = rowl_pkg::next_slot(wr_slot_q);
	assign rd_next   = full_q ? rowl_pkg::next_slot(rd_slot_q) : rd_slot_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rowl_pkg::ST_IDLE: begin
				if (item.valid) begin
					state_nxt = (item.operation == rowl_pkg::OP_FIND) ?
						rowl_pkg::ST_FIND : rowl_pkg::ST_ADD;
				end
			end
			rowl_pkg::ST_ADD: begin
				state_nxt = rowl_pkg::ST_RESP;
			end
			rowl_pkg::ST_FIND: begin
				if (find_hit || walk_last) begin
					state_nxt = rowl_pkg::ST_RESP;
				end
			end
			rowl_pkg::ST_RESP: begin
				if (out_free) begin
					state_nxt = rowl_pkg::ST_IDLE;
				end
			end
			default: state_nxt = rowl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item.ready   = 1'b0;
		mreq.we      = 1'b0;
		mreq.waddr   = wr_slot_q;
		mreq.wdata   = '{handle: handle_q, size: size_q};
		mreq.raddr   = walk_slot_q;
		unique case (state_q)
			rowl_pkg::ST_IDLE: begin
				item.ready = 1'b1;
				mreq.raddr = (item.operation == rowl_pkg::OP_FIND) ? rd_slot_q : wr_slot_q;
			end
			rowl_pkg::ST_ADD: begin
				mreq.we = 1'b1;
			end
			rowl_pkg::ST_FIND: begin
			end
			rowl_pkg::ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rowl_pkg::ST_IDLE;
			wr_slot_q   <= '0;
			rd_slot_q   <= '0;
			full_q      <= 1'b0;
			walk_slot_q <= '0;
			proc_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == rowl_pkg::ST_IDLE && item.valid) begin
				walk_slot_q <= rowl_pkg::next_slot(rd_slot_q);
				proc_q      <= '0;
			end
			if (state_q == rowl_pkg::ST_ADD) begin
				wr_slot_q <= wr_next;
				rd_slot_q <= rd_next;
				full_q    <= full_q || (wr_next == rd_next);
			end
			if (state_q == rowl_pkg::ST_FIND) begin
				walk_slot_q <= rowl_pkg::next_slot(walk_slot_q);
				proc_q      <= rowl_pkg::slot_t'(proc_q + 1'b1);
			end
			if (state_q == rowl_pkg::ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rowl_pkg::ST_IDLE && item.valid) begin
			handle_q <= item.record_handle;
			size_q   <= item.record_size;
			rem_q    <= item.byte_offset;
		end
		if (state_q == rowl_pkg::ST_ADD) begin
			res_hit_q    <= full_q;
			res_handle_q <= full_q ? rdata.handle : '0;
			res_size_q   <= full_q ? rdata.size : '0;
			res_off_q    <= '0;
		end
		if (state_q == rowl_pkg::ST_FIND) begin
			if (find_hit) begin
				res_hit_q    <= 1'b1;
				res_handle_q <= rdata.handle;
				res_size_q   <= rdata.size;
				res_off_q    <= rem_q[rowl_pkg::SIZE_W-1:0];
			end else begin
				rem_q        <= rem_q - rowl_pkg::OFFSET_W'(rdata.size);
				res_hit_q    <= 1'b0;
				res_handle_q <= '0;
				res_size_q   <= '0;
				res_off_q    <= '0;
			end
		end
		if (state_q == rowl_pkg::ST_RESP && out_free) begin
			out_hit_q    <= res_hit_q;
			out_handle_q <= res_handle_q;
			out_size_q   <= res_size_q;
			out_off_q    <= res_off_q;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.hit              = out_hit_q;
	assign result.found_handle     = out_handle_q;
	assign result.found_size       = out_size_q;
	assign result.offset_in_record = out_off_q;

endmodule

@@ hdl/rowl_store.sv @@
// Record memory with per-entry valid bits and a registered read port.
`timescale 1ns / 1ps

module rowl_store (
	input  logic               clk,
	input  logic               arst_n,
	input  rowl_pkg::mem_req_t req,
	output rowl_pkg::entry_t   rdata
);

	rowl_pkg::entry_t              mem_q [rowl_pkg::DEPTH];
	logic [rowl_pkg::DEPTH-1:0]    vld_q;
	rowl_pkg::entry_t              rd_s1;
	logic                          rvld_s1;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rd_s1 <= mem_q[req.raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[req.waddr] <= 1'b1;
			end
			rvld_s1 <= vld_q[req.raddr];
		end
	end

	// unwritten entries read as empty records
	assign rdata = rvld_s1 ? rd_s1 : '0;

endmodule

@@ hdl/rowl_checker.sv @@
// Port-level checks for the write-record ring, bound to the top level.
`timescale 1ns / 1ps

module rowl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          hit,
	input logic [rowl_pkg::HANDLE_W-1:0] found_handle,
	input logic [rowl_pkg::SIZE_W-1:0]   found_size,
	input logic [rowl_pkg::SIZE_W-1:0]   offset_in_record
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(found_handle)
			&& $stable(found_size) && $stable(offset_in_record))
		else $error("stalled result word changed");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> found_handle == '0 && found_size == '0
			&& offset_in_record == '0)
		else $error("miss word carries nonzero fields");

	a_off_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> offset_in_record == '0 || offset_in_record < found_size)
		else $error("offset lies outside the located record");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while one is in flight");

endmodule

bind ring_of_writes_offset_lookup_unit rowl_checker u_rowl_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (item.valid),
	.in_ready         (item.ready),
	.out_valid        (result.valid),
	.out_ready        (result.ready),
	.hit              (result.hit),
	.found_handle     (result.found_handle),
	.found_size       (result.found_size),
	.offset_in_record (result.offset_in_record)
);

@@ verif/ring_of_writes_offset_lookup_unit_tb.sv @@
// Self-checking testbench for the write-record ring with eviction and byte-offset lookup.
`timescale 1ns / 1ps

import rowl_pkg::*;

typedef struct packed {
	logic                hit;
	logic [HANDLE_W-1:0] handle;
	logic [SIZE_W-1:0]   size;
	logic [SIZE_W-1:0]   pos;
} lookup_word_t;

class write_ring_scoreboard;
	logic [HANDLE_W-1:0] rec_handle [DEPTH];
	logic [SIZE_W-1:0]   rec_size [DEPTH];
	int unsigned         wr_slot;
	int unsigned         rd_slot;
	bit                  full;
	lookup_word_t        pending [$];
	int                  errors;
	int                  n_add, n_evict, n_find, n_located, n_miss, n_checked;

	function new();
		for (int i = 0; i < DEPTH; i++) begin
			rec_handle[i] = '0;
			rec_size[i]   = '0;
		end
		wr_slot = 0;
		rd_slot = 0;
		full    = 1'b0;
	endfunction

	function int unsigned stored_bytes();
		int unsigned total;
		total = 0;
		for (int i = 0; i < DEPTH; i++)
			total += 32'(rec_size[i]);
		return total;
	endfunction

	function void note_word(op_t op, logic [HANDLE_W-1:0] handle, logic [SIZE_W-1:0] size,
			logic [OFFSET_W-1:0] offset);
		lookup_word_t w;
		int unsigned  left;
		int unsigned  s;
		int           k;
		bit           located;
		w = '0;
		if (op == OP_ADD) begin
			n_add++;
			if (full) begin
				w.hit    = 1'b1;
				w.handle = rec_handle[rd_slot];
				w.size   = rec_size[rd_slot];
				n_evict++;
			end
			rec_handle[wr_slot] = handle;
			rec_size[wr_slot]   = size;
			if (full)
				rd_slot = (rd_slot + 1) % DEPTH;
			wr_slot = (wr_slot + 1) % DEPTH;
			if (wr_slot == rd_slot)
				full = 1'b1;
		end else begin
			n_find++;
			left    = 32'(offset);
			s       = rd_slot;
			located = 1'b0;
			for (k = 0; k < DEPTH && !located; k++) begin
				if (left < 32'(rec_size[s])) begin
					w.hit    = 1'b1;
					w.handle = rec_handle[s];
					w.size   = rec_size[s];
					w.pos    = left[SIZE_W-1:0];
					located  = 1'b1;
				end else begin
					left -= 32'(rec_size[s]);
					s = (s + 1) % DEPTH;
				end
			end
			if (located)
				n_located++;
			else
				n_miss++;
		end
		pending.push_back(w);
	endfunction

	function void check_result(lookup_word_t got);
		lookup_word_t want;
		if (pending.size() == 0) begin
			$error("result word with nothing pending: hit=%0b handle=%h size=%h pos=%h",
				got.hit, got.handle, got.size, got.pos);
			errors++;
			return;
		end
		want = pending.pop_front();
		n_checked++;
		if (got.hit !== want.hit) begin
			$error("hit: expected %0b, got %0b", want.hit, got.hit);
			errors++;
		end
		if (got.handle !== want.handle) begin
			$error("found_handle: expected %h, got %h", want.handle, got.handle);
			errors++;
		end
		if (got.size !== want.size) begin
			$error("found_size: expected %h, got %h", want.size, got.size);
			errors++;
		end
		if (got.pos !== want.pos) begin
			$error("offset_in_record: expected %h, got %h", want.pos, got.pos);
			errors++;
		end
	endfunction
endclass

module ring_of_writes_offset_lookup_unit_tb;

	logic clk;
	logic arst_n;

	rowl_in_if  item_if ();
	rowl_out_if result_if ();

	ring_of_writes_offset_lookup_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if)
	);

	write_ring_scoreboard sb = new();

	bit sender_quiet;
	bit receiver_quiet;
	int results_taken;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [SIZE_W-1:0] pick_size();
		int unsigned r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '0;
		else if (r <= 4)
			return SIZE_W'($urandom_range(1, 64));
		else if (r <= 6)
			return SIZE_W'($urandom_range(1, 4096));
		else
			return SIZE_W'($urandom);
	endfunction

	function automatic logic [OFFSET_W-1:0] pick_offset();
		int unsigned top;
		top = sb.stored_bytes() + 8;
		if (top > 32'hFFFFF)
			top = 32'hFFFFF;
		if ($urandom_range(0, 3) == 0)
			return OFFSET_W'($urandom);
		return OFFSET_W'($urandom_range(0, top));
	endfunction

	task automatic send_word(op_t op, logic [HANDLE_W-1:0] handle, logic [SIZE_W-1:0] size,
			logic [OFFSET_W-1:0] offset);
		int gap;
		gap = sender_quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid         <= 1'b1;
		item_if.operation     <= op;
		item_if.record_handle <= handle;
		item_if.record_size   <= size;
		item_if.byte_offset   <= offset;
		do @(posedge clk); while (!item_if.ready);
		sb.note_word(op, handle, size, offset);
	endtask

	initial begin : drive_words
		int i;
		item_if.valid         <= 1'b0;
		item_if.operation     <= OP_ADD;
		item_if.record_handle <= '0;
		item_if.record_size   <= '0;
		item_if.byte_offset   <= '0;
		arst_n                <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(OP_FIND, $urandom, SIZE_W'($urandom), '0);
		send_word(OP_FIND, $urandom, SIZE_W'($urandom), 20'hFFFFF);
		send_word(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, OFFSET_W'($urandom));
		send_word(OP_ADD, 32'h0000_0000, 16'h0000, OFFSET_W'($urandom));
		send_word(OP_ADD, 32'hA5A5_5A5A, 16'h0001, OFFSET_W'($urandom));
		send_word(OP_FIND, $urandom, SIZE_W'($urandom), 20'd0);
		send_word(OP_FIND, $urandom, SIZE_W'($urandom), 20'd65535);
		send_word(OP_FIND, $urandom, SIZE_W'($urandom), 20'd65536);
		send_word(OP_FIND, $urandom, SIZE_W'($urandom), 20'hFFFFF);
		for (i = 0; i < 13; i++)
			send_word(OP_ADD, $urandom, pick_size(), OFFSET_W'($urandom));
		send_word(OP_ADD, $urandom, 16'h0010, OFFSET_W'($urandom));
		send_word(OP_FIND, $urandom, SIZE_W'($urandom), 20'd0);
		send_word(OP_FIND, $urandom, SIZE_W'($urandom), 20'hFFFFF);

		for (i = 0; i < 700; i++) begin
			if (i % 48 == 0)
				sender_quiet = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 99) < 45)
				send_word(OP_ADD, $urandom, pick_size(), OFFSET_W'($urandom));
			else
				send_word(OP_FIND, $urandom, SIZE_W'($urandom), pick_offset());
		end
		item_if.valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);

		$display("Run covered %0d adds (%0d evicting) and %0d finds (%0d located, %0d missed).",
			sb.n_add, sb.n_evict, sb.n_find, sb.n_located, sb.n_miss);
		$display("%0d result words checked, with random idling on both sides.", sb.n_checked);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : take_results
		int           stall;
		lookup_word_t got;
		result_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (results_taken % 40 == 0)
				receiver_quiet = ($urandom_range(0, 2) == 0);
			if (results_taken == 120)
				stall = 300;
			else
				stall = receiver_quiet ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!result_if.valid);
			got.hit    = result_if.hit;
			got.handle = result_if.found_handle;
			got.size   = result_if.found_size;
			got.pos    = result_if.offset_in_record;
			sb.check_result(got);
			results_taken++;
		end
	end

endmodule
